/* rtl/core/gha_pkg.sv */
// Shared types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned IDX_W    = 20;
  localparam int unsigned GEN_W    = 12;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIDX_W   = 8;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_RSVD    = 2'd3;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SIDX_W-1:0]   slot_index;
  } rsp_t;

  typedef struct packed {
    logic             in_use;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
  } ctl_sts_t;

endpackage

/* rtl/core/generational_handle_allocator.sv */
// Generational handle allocator top level: sequencer plus datapath.
// A request beat passes capture and free stack read, slot table read, then
// execute and table write, which loads the result register; one request is in
// flight at a time, and a stalled result beat holds the execute step.
// Reset: synchronous active-low rst_n clears the counters and handshake state;
// slot and stack memories need no clearing: the open and free counts bound reads.
module generational_handle_allocator #(
  parameter int unsigned NUM_SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gha_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gha_pkg::rsp_t out_data
);

  gha_pkg::ctl_cmd_t ctl_cmd;
  gha_pkg::ctl_sts_t ctl_sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  gha_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/gha_ctrl.sv */
// Request sequencer: capture, slot table fetch, execute and result load.
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gha_pkg::ctl_sts_t sts,
  output gha_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture  = 1'b1;
          state_nxt    = ST_FETCH;
          in_ready_nxt = 1'b0;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register can take the beat
        if (!sts.out_full) begin
          cmd.exec     = 1'b1;
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

/* rtl/core/gha_dp.sv */
// Datapath: slot table, free stack, counters and result register.
module gha_dp #(
  parameter int unsigned NUM_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gha_pkg::req_t     in_data,
  input  gha_pkg::ctl_cmd_t cmd,
  output gha_pkg::ctl_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output gha_pkg::rsp_t     out_data
);

  localparam int unsigned IW  = $clog2(NUM_SLOTS);
  localparam int unsigned CW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned XIW = gha_pkg::IDX_W;
  localparam int unsigned XW  = (CW > XIW) ? CW : XIW;
  localparam int unsigned GW  = gha_pkg::GEN_W;

  gha_pkg::slot_entry_t slot_mem_r [NUM_SLOTS];
  logic [IW-1:0]        stack_mem_r [NUM_SLOTS];

  gha_pkg::req_t        req_r;
  gha_pkg::slot_entry_t slot_q_r;
  logic [IW-1:0]        stack_q_r;
  logic [IW-1:0]        slot_addr_r;
  logic [CW-1:0]        free_count_r, free_count_nxt;
  logic [CW-1:0]        slots_opened_r, slots_opened_nxt;
  logic                 out_valid_r;
  gha_pkg::rsp_t        out_data_r, out_data_nxt;

  logic [XIW-1:0]       h_idx;
  logic [GW-1:0]        h_gen;
  logic                 is_alloc;
  logic                 is_release;
  logic                 is_check;
  logic                 have_free;
  logic                 can_open;
  logic                 live;
  logic                 push_ok;
  logic [IW-1:0]        pop_addr;
  logic [IW-1:0]        fetch_addr;
  logic [IW-1:0]        alloc_slot;
  logic [XIW-1:0]       alloc_slot_x;
  logic [GW-1:0]        alloc_gen;
  logic                 slot_we;
  logic [IW-1:0]        slot_wa;
  gha_pkg::slot_entry_t slot_wd;
  logic                 push_we;

  assign h_idx      = req_r.handle[XIW-1:0];
  assign h_gen      = req_r.handle[gha_pkg::HANDLE_W-1 -: GW];
  assign is_alloc   = (req_r.req_type == gha_pkg::REQ_ALLOC);
  assign is_release = (req_r.req_type == gha_pkg::REQ_RELEASE);
  assign is_check   = (req_r.req_type == gha_pkg::REQ_CHECK);
  assign have_free  = (free_count_r != '0);
  assign can_open   = (slots_opened_r < CW'(NUM_SLOTS));
  assign push_ok    = (free_count_r < CW'(NUM_SLOTS));
  assign pop_addr   = IW'(free_count_r - CW'(1));
  assign fetch_addr = is_alloc ? stack_q_r : IW'(h_idx);

  assign live = (req_r.handle != '0) && (XW'(h_idx) < XW'(slots_opened_r)) &&
                slot_q_r.in_use && (slot_q_r.gen == h_gen);

  assign alloc_slot   = have_free ? slot_addr_r : IW'(slots_opened_r);
  assign alloc_slot_x = XIW'(alloc_slot);
  // a never-opened slot is given generation one
  assign alloc_gen    = have_free ? (slot_q_r.gen + GW'(1)) : GW'(1);

  always_comb begin
    free_count_nxt          = free_count_r;
    slots_opened_nxt        = slots_opened_r;
    slot_we                 = 1'b0;
    slot_wa                 = slot_addr_r;
    slot_wd                 = slot_q_r;
    push_we                 = 1'b0;
    out_data_nxt.status     = gha_pkg::STAT_INVALID;
    out_data_nxt.handle_out = req_r.handle;
    out_data_nxt.slot_index = h_idx[gha_pkg::SIDX_W-1:0];
    if (is_alloc) begin
      if (have_free || can_open) begin
        if (have_free) begin
          free_count_nxt = free_count_r - CW'(1);
        end else begin
          slots_opened_nxt = slots_opened_r + CW'(1);
        end
        slot_we                 = 1'b1;
        slot_wa                 = alloc_slot;
        slot_wd.in_use          = 1'b1;
        slot_wd.gen             = alloc_gen;
        out_data_nxt.status     = gha_pkg::STAT_OK;
        out_data_nxt.handle_out = {alloc_gen, alloc_slot_x};
        out_data_nxt.slot_index = alloc_slot_x[gha_pkg::SIDX_W-1:0];
      end else begin
        out_data_nxt.status     = gha_pkg::STAT_FULL;
        out_data_nxt.handle_out = '0;
        out_data_nxt.slot_index = '0;
      end
    end else if (is_release) begin
      if (live && push_ok) begin
        slot_we             = 1'b1;
        slot_wd.in_use      = 1'b0;
        push_we             = 1'b1;
        free_count_nxt      = free_count_r + CW'(1);
        out_data_nxt.status = gha_pkg::STAT_OK;
      end
    end else if (is_check) begin
      out_data_nxt.status = live ? gha_pkg::STAT_OK : gha_pkg::STAT_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= in_data;
      stack_q_r <= stack_mem_r[pop_addr];
    end
    if (cmd.exec && push_we) begin
      stack_mem_r[IW'(free_count_r)] <= IW'(h_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      slot_addr_r <= fetch_addr;
      slot_q_r    <= slot_mem_r[fetch_addr];
    end
    if (cmd.exec && slot_we) begin
      slot_mem_r[slot_wa] <= slot_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r   <= '0;
      slots_opened_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        free_count_r   <= free_count_nxt;
        slots_opened_r <= slots_opened_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.out_full = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

/* rtl/core/gha_checker.sv */
// Port-level assertions for the generational handle allocator, with bind.
module gha_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input gha_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_ready,
  input gha_pkg::rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request beat taken while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != gha_pkg::STAT_RSVD)
    else $error("reserved status code on result beat");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == gha_pkg::STAT_FULL |->
      out_data.handle_out == '0 && out_data.slot_index == '0)
    else $error("full result beat carries a nonzero handle");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/tb_generational_handle_allocator.sv */
// Testbench for the generational handle allocator: random and directed beats.
`timescale 1ns / 1ps

module tb_generational_handle_allocator;

  localparam int unsigned NUM_SLOTS  = 256;
  localparam int unsigned RAND_ITEMS = 1100;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned LIMIT      = 1000000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_t;

  class handle_ledger;
    bit                         in_use [NUM_SLOTS];
    logic [gha_pkg::GEN_W-1:0]  gen [NUM_SLOTS];
    logic [gha_pkg::SIDX_W-1:0] free_stack [NUM_SLOTS];
    int unsigned                free_count;
    int unsigned                opened;
    int unsigned                live_count;
    int unsigned                full_seen;
    int unsigned                fails;
    gha_pkg::rsp_t              expected_q [$];

    function new();
      foreach (gen[i]) begin
        in_use[i]     = 1'b0;
        gen[i]        = '0;
        free_stack[i] = '0;
      end
      free_count = 0;
      opened     = 0;
      live_count = 0;
      full_seen  = 0;
      fails      = 0;
    endfunction

    function bit is_live(logic [gha_pkg::HANDLE_W-1:0] h);
      logic [gha_pkg::IDX_W-1:0]  idx;
      logic [gha_pkg::SIDX_W-1:0] s;
      idx = h[gha_pkg::IDX_W-1:0];
      s   = idx[gha_pkg::SIDX_W-1:0];
      if (h == '0 || idx >= opened) return 1'b0;
      return in_use[s] && gen[s] == h[gha_pkg::HANDLE_W-1:gha_pkg::IDX_W];
    endfunction

    function void note_request(gha_pkg::req_t r);
      gha_pkg::rsp_t              e;
      logic [gha_pkg::SIDX_W-1:0] slot;
      logic [gha_pkg::IDX_W-1:0]  idx;
      idx          = r.handle[gha_pkg::IDX_W-1:0];
      e.status     = gha_pkg::STAT_INVALID;
      e.handle_out = r.handle;
      e.slot_index = idx[gha_pkg::SIDX_W-1:0];
      case (r.req_type)
        gha_pkg::REQ_ALLOC: begin
          if (free_count > 0 || opened < NUM_SLOTS) begin
            if (free_count > 0) begin
              free_count--;
              slot = free_stack[free_count];
            end else begin
              slot = gha_pkg::SIDX_W'(opened);
              opened++;
            end
            gen[slot]    = gen[slot] + 1'b1;
            in_use[slot] = 1'b1;
            live_count++;
            e.status     = gha_pkg::STAT_OK;
            e.handle_out = {gen[slot], {(gha_pkg::IDX_W - gha_pkg::SIDX_W){1'b0}}, slot};
            e.slot_index = slot;
          end else begin
            e.status     = gha_pkg::STAT_FULL;
            e.handle_out = '0;
            e.slot_index = '0;
            full_seen++;
          end
        end
        gha_pkg::REQ_RELEASE: begin
          if (is_live(r.handle) && free_count < NUM_SLOTS) begin
            in_use[idx[gha_pkg::SIDX_W-1:0]] = 1'b0;
            free_stack[free_count]           = idx[gha_pkg::SIDX_W-1:0];
            free_count++;
            live_count--;
            e.status = gha_pkg::STAT_OK;
          end
        end
        gha_pkg::REQ_CHECK: begin
          if (is_live(r.handle)) e.status = gha_pkg::STAT_OK;
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_response(gha_pkg::rsp_t a);
      gha_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected beat: status %0d handle %h slot %0d",
                   a.status, a.handle_out, a.slot_index);
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status || a.handle_out !== e.handle_out ||
          a.slot_index !== e.slot_index) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: status %0d/%0d handle %h/%h slot %0d/%0d (exp/act)",
                   e.status, a.status, e.handle_out, a.handle_out,
                   e.slot_index, a.slot_index);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  gha_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_ready;
  gha_pkg::rsp_t  out_data;

  handle_ledger ledger;
  int unsigned  cycle_cnt = 0;
  int unsigned  idle_pct  = 0;
  bit           quiet     = 1'b0;
  bit           hold_req  = 1'b0;

  generational_handle_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_response(out_data);
  end

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  function automatic gha_pkg::req_t mk(logic [1:0] t, logic [gha_pkg::HANDLE_W-1:0] h);
    gha_pkg::req_t r;
    r.req_type = t;
    r.handle   = h;
    return r;
  endfunction

  function automatic logic [gha_pkg::HANDLE_W-1:0] slot_handle(int unsigned s,
                                                               logic [gha_pkg::GEN_W-1:0] g);
    return {g, {(gha_pkg::IDX_W - gha_pkg::SIDX_W){1'b0}}, gha_pkg::SIDX_W'(s)};
  endfunction

  function automatic int find_live();
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, NUM_SLOTS - 1);
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      s = (start + i) % NUM_SLOTS;
      if (ledger.in_use[s] && slot_handle(s, ledger.gen[s]) != '0) return int'(s);
    end
    return -1;
  endfunction

  function automatic logic [gha_pkg::HANDLE_W-1:0] known_handle(int unsigned live_pct);
    int                        s;
    int unsigned               slot;
    logic [gha_pkg::GEN_W-1:0] g;
    s = find_live();
    if (s >= 0 && $urandom_range(0, 99) < live_pct)
      return slot_handle(s, ledger.gen[s]);
    if (ledger.opened == 0) return $urandom();
    slot = $urandom_range(0, ledger.opened - 1);
    g    = ledger.gen[slot] - gha_pkg::GEN_W'($urandom_range(0, 2));
    return slot_handle(slot, g);
  endfunction

  function automatic gha_pkg::req_t noise_item();
    logic [gha_pkg::IDX_W-1:0]    idx;
    logic [gha_pkg::HANDLE_W-1:0] h;
    case ($urandom_range(0, 3))
      0: return mk(REQ_UNUSED, $urandom());
      1: return mk($urandom_range(0, 1) ? gha_pkg::REQ_RELEASE : gha_pkg::REQ_CHECK,
                   $urandom());
      2: begin
        idx = $urandom_range(ledger.opened, (1 << gha_pkg::IDX_W) - 1);
        return mk($urandom_range(0, 1) ? gha_pkg::REQ_RELEASE : gha_pkg::REQ_CHECK,
                  {gha_pkg::GEN_W'($urandom()), idx});
      end
      default: begin
        h = known_handle(100);
        if ($urandom_range(0, 1)) h = '0;
        else h[$urandom_range(0, gha_pkg::HANDLE_W - 1)] ^= 1'b1;
        return mk($urandom_range(0, 1) ? gha_pkg::REQ_RELEASE : gha_pkg::REQ_CHECK, h);
      end
    endcase
  endfunction

  function automatic gha_pkg::req_t make_item(mode_t m);
    int unsigned roll;
    int unsigned a_lim;
    int unsigned r_lim;
    int unsigned c_lim;
    roll = $urandom_range(0, 99);
    case (m)
      MODE_FILL: begin
        a_lim = 80; r_lim = 85; c_lim = 95;
      end
      MODE_DRAIN: begin
        a_lim = 10; r_lim = 80; c_lim = 92;
      end
      default: begin
        a_lim = 35; r_lim = 65; c_lim = 90;
      end
    endcase
    if (roll < a_lim) return mk(gha_pkg::REQ_ALLOC, $urandom());
    if (roll < r_lim)
      return mk(gha_pkg::REQ_RELEASE, known_handle(m == MODE_DRAIN ? 95 : 70));
    if (roll < c_lim) return mk(gha_pkg::REQ_CHECK, known_handle(70));
    return noise_item();
  endfunction

  task automatic send_req(gha_pkg::req_t r);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : rx
    int unsigned n;
    int unsigned pct;
    n   = 0;
    pct = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (n % 128 == 0) pct = pick_idle_pct();
      n++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : tx
    mode_t       mode;
    int unsigned full_mark;
    int unsigned mix_left;
    ledger    = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(mk(gha_pkg::REQ_CHECK, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'hFFFF_FFFF));
    send_req(mk(REQ_UNUSED, 32'hFFFF_FFFF));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'hFFFF_FFFF));
    send_req(mk(gha_pkg::REQ_CHECK, 32'h0010_0000));
    send_req(mk(gha_pkg::REQ_CHECK, 32'h0020_0000));
    send_req(mk(gha_pkg::REQ_CHECK, 32'h0010_0001));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'h0010_0000));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'h0010_0000));
    send_req(mk(gha_pkg::REQ_CHECK, 32'h0010_0000));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'h0010_0002));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'h0010_0001));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_ALLOC, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_CHECK, 32'hFFF0_00FF));
    send_req(mk(REQ_UNUSED, 32'h0000_0000));
    send_req(mk(gha_pkg::REQ_RELEASE, 32'h000F_FFFF));
    send_req(mk(gha_pkg::REQ_CHECK, 32'h0020_0001));
    drain_results();

    mode      = MODE_FILL;
    full_mark = 3;
    mix_left  = 0;
    for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
      if (k % 64 == 0) idle_pct = pick_idle_pct();
      if (k == 300) hold_req = 1'b1;
      if (k == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      case (mode)
        MODE_FILL: begin
          if (ledger.full_seen >= full_mark) mode = MODE_DRAIN;
        end
        MODE_DRAIN: begin
          if (ledger.live_count <= 8) begin
            mode     = MODE_MIX;
            mix_left = 150;
          end
        end
        default: begin
          if (mix_left == 0) begin
            mode      = MODE_FILL;
            full_mark = ledger.full_seen + 3;
          end else begin
            mix_left--;
          end
        end
      endcase
      send_req(make_item(mode));
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (ledger.fails == 0 && ledger.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gha_pkg.sv
rtl/core/gha_ctrl.sv
rtl/core/gha_dp.sv
rtl/core/generational_handle_allocator.sv
rtl/core/gha_checker.sv
verif/tb_generational_handle_allocator.sv
